/* hw/rtl/sfbs_pkg.sv */
// shared types and constants of the flame billboard sampler
package sfbs_pkg;

  localparam int MAX_FRAMES_DEF = 256;

  // register indexes
  localparam logic [2:0] REG_FRAME_TIME  = 3'd0;
  localparam logic [2:0] REG_FRAME_TOTAL = 3'd1;
  localparam logic [2:0] REG_COLUMNS     = 3'd2;
  localparam logic [2:0] REG_ROWS        = 3'd3;
  localparam logic [2:0] REG_PHASE_STEP  = 3'd4;
  localparam logic [2:0] REG_WIDTH_FACT  = 3'd5;
  localparam logic [2:0] REG_HEIGHT_FACT = 3'd6;
  localparam logic [2:0] REG_ALPHAS      = 3'd7;

  // age bands
  localparam logic [1:0] BAND_YOUNG = 2'd0;
  localparam logic [1:0] BAND_MID   = 2'd1;
  localparam logic [1:0] BAND_OLD   = 2'd2;

  localparam logic [12:0] PULSE_BASE = 13'd3686;
  localparam logic [5:0]  PULSE_STEP = 6'd51;
  localparam logic [12:0] RECIP_100  = 13'd5243;  // 2^19 / 100, rounded up
  localparam int          RECIP_SH   = 19;
  localparam logic [20:0] MIN_QUAD   = 21'd128;

  typedef struct packed {
    logic [15:0] age_ms;
    logic [15:0] life_ms;
    logic [7:0]  slot_number;
    logic [15:0] mesh_scale;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  frame_num;
    logic [7:0]  atlas_col;
    logic [7:0]  cell_row;
    logic        flip_horizontal;
    logic [20:0] quad_width;
    logic [20:0] quad_height;
    logic [7:0]  core_green;
    logic [7:0]  core_blue;
    logic [7:0]  core_alpha;
    logic [7:0]  hot_alpha;
    logic [7:0]  glow_alpha;
  } out_word_t;

endpackage

/* hw/rtl/sfbs_div.sv */
// pipelined restoring divider, one quotient bit per stage, with a sideband tag
module sfbs_div import sfbs_pkg::*; #(
  parameter int NW = 16,
  parameter int DW = 16,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag,
  output logic          out_vld,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem,
  output logic [TW-1:0] out_tag
);

  logic          vs [NW];
  logic [DW-1:0] rs [NW];
  logic [NW-1:0] ns [NW];
  logic [NW-1:0] qs [NW];
  logic [DW-1:0] ds [NW];
  logic [TW-1:0] ts [NW];

  for (genvar k = 0; k < NW; k++) begin : g_st
    logic          v_in;
    logic [DW-1:0] r_in;
    logic [NW-1:0] n_in;
    logic [NW-1:0] q_in;
    logic [DW-1:0] d_in;
    logic [TW-1:0] t_in;
    logic [DW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_in = in_vld;
      assign r_in = '0;
      assign n_in = num;
      assign q_in = '0;
      assign d_in = den;
      assign t_in = tag;
    end else begin : g_next
      assign v_in = vs[k-1];
      assign r_in = rs[k-1];
      assign n_in = ns[k-1];
      assign q_in = qs[k-1];
      assign d_in = ds[k-1];
      assign t_in = ts[k-1];
    end

    assign trial = {r_in, n_in[NW-1]};
    assign ge    = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[k] <= 1'b0;
      end else if (en) begin
        vs[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rs[k] <= ge ? DW'(trial - {1'b0, d_in}) : trial[DW-1:0];
        ns[k] <= n_in << 1;
        qs[k] <= (q_in << 1) | NW'(ge);
        ds[k] <= d_in;
        ts[k] <= t_in;
      end
    end
  end

  assign out_vld = vs[NW-1];
  assign quo     = qs[NW-1];
  assign rem     = rs[NW-1];
  assign out_tag = ts[NW-1];

endmodule

/* hw/rtl/sprite_flame_billboard_sampler.sv */
// flame billboard sampler top level: frame, atlas cell, flicker size and heat colors
// accepts one word per cycle unless a stall at the output holds the pipe
// the three bit-per-stage dividers (age / frame time, modulo frame count, split by
// columns) set the depth; a stall at the output freezes the whole pipe
// reset clears all valid bits and loads the register defaults
module sprite_flame_billboard_sampler import sfbs_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // widths that follow from the frame limit
  localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;  // frame number
  localparam int CW = $clog2(MAX_FRAMES + 1);                       // frame count

  // configuration registers
  logic [15:0] frame_time_ms;
  logic [8:0]  frame_total;
  logic [8:0]  atlas_columns;
  logic [8:0]  atlas_rows;
  logic [7:0]  slot_phase_step;
  logic [15:0] width_gain;
  logic [15:0] height_gain;
  logic [15:0] effect_alphas;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_time_ms   <= 16'd1;
      frame_total     <= 9'd1;
      atlas_columns   <= 9'd1;
      atlas_rows      <= 9'd1;
      slot_phase_step <= 8'd0;
      width_gain      <= 16'd4096;
      height_gain     <= 16'd4096;
      effect_alphas   <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_TIME:  frame_time_ms   <= cfg_data;
        REG_FRAME_TOTAL: frame_total     <= cfg_data[8:0];
        REG_COLUMNS:     atlas_columns   <= cfg_data[8:0];
        REG_ROWS:        atlas_rows      <= cfg_data[8:0];
        REG_PHASE_STEP:  slot_phase_step <= cfg_data[7:0];
        REG_WIDTH_FACT:  width_gain      <= cfg_data;
        REG_HEIGHT_FACT: height_gain     <= cfg_data;
        REG_ALPHAS:      effect_alphas   <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective settings; config is to change only while the pipe is empty (not enforced);
  // the registered frame count is then settled long before an item reaches the modulo
  logic [15:0]   ftime;
  logic [8:0]    cols;
  logic [8:0]    rows;
  logic [15:0]   wf;
  logic [15:0]   hf;
  logic [8:0]    cnt_raw;
  logic [17:0]   cells;
  logic [17:0]   cnt_cl;
  logic [CW-1:0] cnt_eff;

  assign ftime   = (frame_time_ms == '0) ? 16'd1 : frame_time_ms;
  assign cols    = (atlas_columns == '0) ? 9'd1 : atlas_columns;
  assign rows    = (atlas_rows == '0) ? 9'd1 : atlas_rows;
  assign wf      = (width_gain == '0) ? 16'd4096 : width_gain;
  assign hf      = (height_gain == '0) ? 16'd4096 : height_gain;
  assign cnt_raw = (frame_total == '0) ? 9'd1 : frame_total;
  assign cells   = 18'(cols) * 18'(rows);

  always_comb begin
    cnt_cl = (18'(cnt_raw) > cells) ? cells : 18'(cnt_raw);
    if (cnt_cl > 18'(MAX_FRAMES)) begin
      cnt_cl = 18'(MAX_FRAMES);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_eff <= CW'(1);
    end else begin
      cnt_eff <= cnt_cl[CW-1:0];
    end
  end

  // whole pipe moves unless a finished word is held at the output
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // ---- entry: clamp age, pick the heat band, phase offset and base sizes
  typedef struct packed {
    logic [1:0]  band;
    logic [7:0]  slot;
    logic [15:0] phase;
    logic [19:0] w0;
    logic [19:0] h0;
  } tag1_t;

  logic [15:0] life;
  logic [15:0] age;
  logic [15:0] mesh;
  logic [31:0] mw;
  logic [31:0] mh;
  tag1_t       t1_in;

  assign life = (in_word.life_ms == '0) ? 16'd1 : in_word.life_ms;
  assign age  = (in_word.age_ms > life) ? life : in_word.age_ms;
  assign mesh = (in_word.mesh_scale == '0) ? 16'd4096 : in_word.mesh_scale;
  assign mw   = 32'(mesh) * 32'(wf);
  assign mh   = 32'(mesh) * 32'(hf);

  always_comb begin
    // age < life/4 and age < 2*life/3 without dividing
    if ((19'(age) << 2) + 19'd4 <= 19'(life)) begin
      t1_in.band = BAND_YOUNG;
    end else if (19'(age) * 19'd3 + 19'd3 <= (19'(life) << 1)) begin
      t1_in.band = BAND_MID;
    end else begin
      t1_in.band = BAND_OLD;
    end
    t1_in.slot  = in_word.slot_number;
    t1_in.phase = 16'(in_word.slot_number) * 16'(slot_phase_step);
    t1_in.w0    = mw[31:12];
    t1_in.h0    = mh[31:12];
  end

  logic              d1_vld;
  logic [15:0]       d1_quo;
  logic [15:0]       d1_rem;
  logic [$bits(tag1_t)-1:0] d1_tag;
  tag1_t             t1_out;

  // age / frame time
  sfbs_div #(.NW(16), .DW(16), .TW($bits(tag1_t))) u_div_time (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_vld  (in_valid),
    .num     (age),
    .den     (ftime),
    .tag     (t1_in),
    .out_vld (d1_vld),
    .quo     (d1_quo),
    .rem     (d1_rem),
    .out_tag (d1_tag)
  );

  assign t1_out = tag1_t'(d1_tag);

  // ---- second divider: add the slot phase, reduce modulo the frame count
  typedef struct packed {
    logic [1:0]  band;
    logic [7:0]  slot;
    logic [19:0] w0;
    logic [19:0] h0;
  } tag2_t;

  logic [16:0] step_sum;
  tag2_t       t2_in;

  assign step_sum = 17'(d1_quo) + 17'(t1_out.phase);
  assign t2_in    = '{band: t1_out.band, slot: t1_out.slot, w0: t1_out.w0, h0: t1_out.h0};

  logic              d2_vld;
  logic [16:0]       d2_quo;
  logic [CW-1:0]     d2_rem;
  logic [$bits(tag2_t)-1:0] d2_tag;
  tag2_t             t2_out;

  sfbs_div #(.NW(17), .DW(CW), .TW($bits(tag2_t))) u_div_count (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_vld  (d1_vld),
    .num     (step_sum),
    .den     (cnt_eff),
    .tag     (t2_in),
    .out_vld (d2_vld),
    .quo     (d2_quo),
    .rem     (d2_rem),
    .out_tag (d2_tag)
  );

  assign t2_out = tag2_t'(d2_tag);

  // ---- frame known: flicker pulse, flip and alpha products
  typedef struct packed {
    logic [FW-1:0] frame;
    logic          flip;
    logic [1:0]    band;
    logic [12:0]   pulse;
    logic [19:0]   w0;
    logic [19:0]   h0;
    logic [14:0]   hot_prod;
    logic [14:0]   glow_prod;
  } tag3_t;

  logic [FW-1:0] frame;
  logic [4:0]    f5;
  logic [4:0]    s5;
  logic [4:0]    ph;
  logic [4:0]    tri_v;
  logic [6:0]    hot_pct;
  logic [6:0]    glow_pct;
  tag3_t         t3_in;

  assign frame = d2_rem[FW-1:0];
  assign f5    = 5'(frame);
  assign s5    = t2_out.slot[4:0];
  assign ph    = f5 * 5'd5 + s5 * 5'd3;                 // wraps mod 32
  assign tri_v = (ph <= 5'd16) ? ph : 5'(6'd32 - 6'(ph));

  always_comb begin
    case (t2_out.band)
      BAND_YOUNG: begin
        hot_pct  = 7'd100;
        glow_pct = 7'd100;
      end
      BAND_MID: begin
        hot_pct  = 7'd83;
        glow_pct = 7'd84;
      end
      default: begin
        hot_pct  = 7'd61;
        glow_pct = 7'd63;
      end
    endcase
    t3_in.frame     = frame;
    t3_in.flip      = t2_out.slot[0] ^ frame[0];
    t3_in.band      = t2_out.band;
    t3_in.pulse     = PULSE_BASE + 13'(tri_v) * 13'(PULSE_STEP);
    t3_in.w0        = t2_out.w0;
    t3_in.h0        = t2_out.h0;
    t3_in.hot_prod  = 15'(effect_alphas[7:0]) * 15'(hot_pct);
    t3_in.glow_prod = 15'(effect_alphas[15:8]) * 15'(glow_pct);
  end

  logic              d3_vld;
  logic [FW-1:0]     d3_quo;
  logic [8:0]        d3_rem;
  logic [$bits(tag3_t)-1:0] d3_tag;
  tag3_t             t3_out;

  // frame split into atlas row and column
  sfbs_div #(.NW(FW), .DW(9), .TW($bits(tag3_t))) u_div_cols (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_vld  (d2_vld),
    .num     (frame),
    .den     (cols),
    .tag     (t3_in),
    .out_vld (d3_vld),
    .quo     (d3_quo),
    .rem     (d3_rem),
    .out_tag (d3_tag)
  );

  assign t3_out = tag3_t'(d3_tag);

  // ---- output stage: flicker products, percent divide, colors
  logic [32:0] wq;
  logic [32:0] hq;
  logic [20:0] w_sz;
  logic [20:0] h_sz;
  logic [27:0] hot_q;
  logic [27:0] glow_q;
  out_word_t   res;

  assign wq     = 33'(t3_out.w0) * 33'(t3_out.pulse);
  assign hq     = 33'(t3_out.h0) * 33'(t3_out.pulse);
  assign w_sz   = wq[32:12];
  assign h_sz   = hq[32:12];
  assign hot_q  = 28'(t3_out.hot_prod) * 28'(RECIP_100);
  assign glow_q = 28'(t3_out.glow_prod) * 28'(RECIP_100);

  always_comb begin
    res.frame_num       = 8'(t3_out.frame);
    res.atlas_col       = d3_rem[7:0];
    res.cell_row        = 8'(d3_quo);
    res.flip_horizontal = t3_out.flip;
    res.quad_width      = (w_sz < MIN_QUAD) ? MIN_QUAD : w_sz;
    res.quad_height     = (h_sz < MIN_QUAD) ? MIN_QUAD : h_sz;
    res.hot_alpha       = 8'(hot_q >> RECIP_SH);
    res.glow_alpha      = 8'(glow_q >> RECIP_SH);
    case (t3_out.band)
      BAND_YOUNG: begin
        res.core_green = 8'd238;
        res.core_blue  = 8'd196;
        res.core_alpha = 8'd215;
      end
      BAND_MID: begin
        res.core_green = 8'd205;
        res.core_blue  = 8'd132;
        res.core_alpha = 8'd197;
      end
      default: begin
        res.core_green = 8'd154;
        res.core_blue  = 8'd72;
        res.core_alpha = 8'd172;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= d3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word <= res;
    end
  end

endmodule

/* sim/tb_top.sv */
// testbench for the flame billboard sampler: directed and random words checked against a predictor
module tb_top;
  import sfbs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_word;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  // shadow copy of the register file
  logic [15:0] sh_ftime;
  logic [8:0]  sh_total;
  logic [8:0]  sh_cols;
  logic [8:0]  sh_rows;
  logic [7:0]  sh_phase;
  logic [15:0] sh_wf;
  logic [15:0] sh_hf;
  logic [15:0] sh_alphas;

  out_word_t expected_words[$];
  int        mismatch_count;
  bit        quiet_mode;   // no idling in the last part of the run
  int        out_idle_left;

  sprite_flame_billboard_sampler DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // truncated percentage, capped at 255
  function automatic logic [7:0] scaled_alpha(logic [7:0] base, int pct);
    int v;
    v = base * pct / 100;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // predicted billboard attributes for one particle
  function automatic out_word_t billboard_of(in_word_t w);
    out_word_t r;
    longint unsigned age, life, slot, mesh, ft, cnt, cols, rows, wf, hf;
    longint unsigned frame, p, tri_v, pulse, wq, hq;
    int ap, hp, gp;
    age   = w.age_ms;
    life  = (w.life_ms == 0) ? 1 : w.life_ms;
    slot  = w.slot_number;
    mesh  = (w.mesh_scale == 0) ? 4096 : w.mesh_scale;
    ft    = (sh_ftime == 0) ? 1 : sh_ftime;
    cnt   = (sh_total == 0) ? 1 : sh_total;
    cols  = (sh_cols == 0) ? 1 : sh_cols;
    rows  = (sh_rows == 0) ? 1 : sh_rows;
    wf    = (sh_wf == 0) ? 4096 : sh_wf;
    hf    = (sh_hf == 0) ? 4096 : sh_hf;
    if (age > life) age = life;
    if (cnt > cols * rows) cnt = cols * rows;
    if (cnt > MAX_FRAMES_DEF) cnt = MAX_FRAMES_DEF;
    frame = (age / ft + slot * sh_phase) % cnt;
    p     = (frame * 5 + slot * 3) & 31;
    tri_v = (p <= 16) ? p : 32 - p;
    pulse = 3686 + tri_v * 51;
    wq    = (((mesh * wf) >> 12) * pulse) >> 12;
    hq    = (((mesh * hf) >> 12) * pulse) >> 12;
    if (wq < 128) wq = 128;
    if (hq < 128) hq = 128;
    r.frame_num       = frame[7:0];
    r.atlas_col       = 8'((frame % cols) & 255);
    r.cell_row        = 8'((frame / cols) & 255);
    r.flip_horizontal = slot[0] ^ frame[0];
    r.quad_width      = wq[20:0];
    r.quad_height     = hq[20:0];
    if (age < life / 4) begin
      r.core_green = 8'd238; r.core_blue = 8'd196; ap = 100; hp = 100; gp = 100;
    end else if (age < (life * 2) / 3) begin
      r.core_green = 8'd205; r.core_blue = 8'd132; ap = 92; hp = 83; gp = 84;
    end else begin
      r.core_green = 8'd154; r.core_blue = 8'd72; ap = 80; hp = 61; gp = 63;
    end
    r.core_alpha = scaled_alpha(8'd215, ap);
    r.hot_alpha  = scaled_alpha(sh_alphas[7:0], hp);
    r.glow_alpha = scaled_alpha(sh_alphas[15:8], gp);
    return r;
  endfunction

  // receiver: random stall bursts, checks each accepted word
  always @(posedge clk) begin
    out_word_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: %p", out_word);
        mismatch_count++;
      end else begin
        e = expected_words.pop_front();
        if (out_word.frame_num !== e.frame_num) begin
          $error("frame_num exp %0d got %0d", e.frame_num, out_word.frame_num);
          mismatch_count++;
        end
        if (out_word.atlas_col !== e.atlas_col) begin
          $error("atlas_col exp %0d got %0d", e.atlas_col, out_word.atlas_col);
          mismatch_count++;
        end
        if (out_word.cell_row !== e.cell_row) begin
          $error("cell_row exp %0d got %0d", e.cell_row, out_word.cell_row);
          mismatch_count++;
        end
        if (out_word.flip_horizontal !== e.flip_horizontal) begin
          $error("flip_horizontal exp %0d got %0d", e.flip_horizontal,
                 out_word.flip_horizontal);
          mismatch_count++;
        end
        if (out_word.quad_width !== e.quad_width) begin
          $error("quad_width exp %0d got %0d", e.quad_width, out_word.quad_width);
          mismatch_count++;
        end
        if (out_word.quad_height !== e.quad_height) begin
          $error("quad_height exp %0d got %0d", e.quad_height, out_word.quad_height);
          mismatch_count++;
        end
        if (out_word.core_green !== e.core_green) begin
          $error("core_green exp %0d got %0d", e.core_green, out_word.core_green);
          mismatch_count++;
        end
        if (out_word.core_blue !== e.core_blue) begin
          $error("core_blue exp %0d got %0d", e.core_blue, out_word.core_blue);
          mismatch_count++;
        end
        if (out_word.core_alpha !== e.core_alpha) begin
          $error("core_alpha exp %0d got %0d", e.core_alpha, out_word.core_alpha);
          mismatch_count++;
        end
        if (out_word.hot_alpha !== e.hot_alpha) begin
          $error("hot_alpha exp %0d got %0d", e.hot_alpha, out_word.hot_alpha);
          mismatch_count++;
        end
        if (out_word.glow_alpha !== e.glow_alpha) begin
          $error("glow_alpha exp %0d got %0d", e.glow_alpha, out_word.glow_alpha);
          mismatch_count++;
        end
      end
    end
  end

  // stall pattern changes on the falling edge
  always @(negedge clk) begin
    if (rst || quiet_mode) begin
      out_stall <= 1'b0;
      out_idle_left = 0;
    end else if (out_idle_left > 0) begin
      out_idle_left--;
      out_stall <= (out_idle_left != 0);
    end else if ($urandom_range(0, 9) == 0) begin
      out_idle_left = $urandom_range(1, 15);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // one register write while the pipe is empty
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_FRAME_TIME:  sh_ftime  = val;
      REG_FRAME_TOTAL: sh_total  = val[8:0];
      REG_COLUMNS:     sh_cols   = val[8:0];
      REG_ROWS:        sh_rows   = val[8:0];
      REG_PHASE_STEP:  sh_phase  = val[7:0];
      REG_WIDTH_FACT:  sh_wf     = val;
      REG_HEIGHT_FACT: sh_hf     = val;
      default:         sh_alphas = val;
    endcase
  endtask

  // send one particle word, with a random gap before it unless quiet
  task automatic send_particle(in_word_t w);
    int gap;
    if (!quiet_mode && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_words.push_back(billboard_of(w));
    @(negedge clk);
  endtask

  // drop valid, wait for the pipe to drain, then keep idling before returning
  task automatic drain_pipe();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (expected_words.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (60) @(negedge clk);
  endtask

  function automatic in_word_t random_particle();
    in_word_t w;
    w.life_ms     = 16'($urandom());
    w.age_ms      = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                                 : 16'($urandom_range(0, w.life_ms));
    w.slot_number = 8'($urandom());
    w.mesh_scale  = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom());
    return w;
  endfunction

  task automatic random_config();
    write_reg(REG_FRAME_TIME,  ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                                            : 16'($urandom_range(0, 200)));
    write_reg(REG_FRAME_TOTAL, 16'($urandom_range(0, 256)));
    write_reg(REG_COLUMNS,     16'($urandom_range(0, 256)));
    write_reg(REG_ROWS,        16'($urandom_range(0, 256)));
    write_reg(REG_PHASE_STEP,  16'($urandom_range(0, 255)));
    write_reg(REG_WIDTH_FACT,  16'($urandom()));
    write_reg(REG_HEIGHT_FACT, 16'($urandom()));
    write_reg(REG_ALPHAS,      16'($urandom()));
  endtask

  // register defaults, extremes of every input field and the age bands
  task automatic test_directed();
    in_word_t w;
    w = '{age_ms: 16'd0, life_ms: 16'd0, slot_number: 8'd0, mesh_scale: 16'd0};
    send_particle(w);
    w = '{age_ms: 16'hFFFF, life_ms: 16'hFFFF, slot_number: 8'hFF, mesh_scale: 16'hFFFF};
    send_particle(w);
    drain_pipe();
    // large atlas, wide factors, full alphas
    write_reg(REG_FRAME_TIME, 16'd0);
    write_reg(REG_FRAME_TOTAL, 16'd256);
    write_reg(REG_COLUMNS, 16'd256);
    write_reg(REG_ROWS, 16'd256);
    write_reg(REG_PHASE_STEP, 16'h00FF);
    write_reg(REG_WIDTH_FACT, 16'hFFFF);
    write_reg(REG_HEIGHT_FACT, 16'd0);
    write_reg(REG_ALPHAS, 16'hFFFF);
    // band edges around a quarter and two thirds of life
    for (int a = 0; a < 8; a++) begin
      w.life_ms     = 16'd100;
      w.age_ms      = (a == 0) ? 16'd0 : (a == 1) ? 16'd24 : (a == 2) ? 16'd25 :
                      (a == 3) ? 16'd65 : (a == 4) ? 16'd66 : (a == 5) ? 16'd67 :
                      (a == 6) ? 16'd100 : 16'd150;
      w.slot_number = 8'(a * 37);
      w.mesh_scale  = 16'h1000;
      send_particle(w);
    end
    // tiny mesh hits the size floor
    w = '{age_ms: 16'd3, life_ms: 16'd1, slot_number: 8'h55, mesh_scale: 16'd1};
    send_particle(w);
    w = '{age_ms: 16'hFFFF, life_ms: 16'h0001, slot_number: 8'hAA, mesh_scale: 16'hFFFF};
    send_particle(w);
    drain_pipe();
    // frame count above columns times rows
    write_reg(REG_FRAME_TOTAL, 16'd200);
    write_reg(REG_COLUMNS, 16'd3);
    write_reg(REG_ROWS, 16'd5);
    write_reg(REG_FRAME_TIME, 16'd7);
    write_reg(REG_ALPHAS, 16'h0080);
    for (int k = 0; k < 8; k++) send_particle(random_particle());
    drain_pipe();
  endtask

  // random phases, each under a fresh register setting
  task automatic test_random(int phases, int per_phase);
    for (int ph = 0; ph < phases; ph++) begin
      random_config();
      for (int k = 0; k < per_phase; k++) send_particle(random_particle());
      drain_pipe();
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_FRAME_TIME;
    cfg_data = '0;
    mismatch_count = 0;
    quiet_mode = 1'b0;
    out_idle_left = 0;
    sh_ftime = 16'd1; sh_total = 9'd1; sh_cols = 9'd1; sh_rows = 9'd1;
    sh_phase = 8'd0; sh_wf = 16'd4096; sh_hf = 16'd4096; sh_alphas = 16'd0;
    repeat (6) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);
    test_directed();
    test_random(15, 100);
    quiet_mode = 1'b1;
    test_random(2, 100);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/sfbs_pkg.sv
hw/rtl/sfbs_div.sv
hw/rtl/sprite_flame_billboard_sampler.sv
sim/tb_top.sv
